/* rtl/core/mvest_pkg.sv */
// ----------------------------------------------------------------------------
// mvest_pkg
// Types and constants shared by the pixel mean variance estimator modules.
// ----------------------------------------------------------------------------
package mvest_pkg;

  localparam logic [63:0] LIM_WIDE  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_SIGMA = 64'h0000_1FFF_FFFF_FFFF;
  localparam logic [63:0] LIM_OUT   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NONE  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q40   = 64'h0000_0100_0000_0000;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_8  = 2'd1;
  localparam logic [1:0] SH_16 = 2'd2;
  localparam logic [1:0] SH_32 = 2'd3;

  localparam logic [1:0] LS_WIDE  = 2'd0;
  localparam logic [1:0] LS_SIGMA = 2'd1;
  localparam logic [1:0] LS_OUT   = 2'd2;
  localparam logic [1:0] LS_NONE  = 2'd3;

  localparam logic [1:0] CFG_LUMA_RED   = 2'd0;
  localparam logic [1:0] CFG_LUMA_GREEN = 2'd1;
  localparam logic [1:0] CFG_LUMA_BLUE  = 2'd2;
  localparam logic [1:0] CFG_CLAMP      = 2'd3;

  localparam logic [15:0] RST_LUMA_RED   = 16'd13933;
  localparam logic [15:0] RST_LUMA_GREEN = 16'd46871;
  localparam logic [15:0] RST_LUMA_BLUE  = 16'd4732;
  localparam logic [15:0] RST_CLAMP      = 16'd5000;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [1:0]         sh;
    logic [1:0]         lim;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] res;
  } unit_rsp_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    mag64 = a[63] ? (64'd0 - a) : a;
  endfunction

endpackage

/* rtl/core/mvest_mul.sv */
// ----------------------------------------------------------------------------
// mvest_mul
// Shared 64x64 multiplier over four 32x32 partial products, shift and saturate.
// ----------------------------------------------------------------------------
module mvest_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mvest_pkg::mul_req_t  req,
  output mvest_pkg::unit_rsp_t rsp
);

  logic [63:0]        am_r, bm_r, pp_r;
  logic               neg_r, busy_r, done_r;
  logic [1:0]         sh_r, lim_r, pidx_r;
  logic [2:0]         cnt_r;
  logic [127:0]       acc_r;
  logic signed [63:0] res_r;

  logic [31:0]  a_part, b_part;
  logic [127:0] pp_sh, shv;
  logic [63:0]  limv, magv;

  assign a_part = cnt_r[1] ? am_r[63:32] : am_r[31:0];
  assign b_part = cnt_r[0] ? bm_r[63:32] : bm_r[31:0];

  always_comb begin
    case (pidx_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'd0};
      default: pp_sh = {32'd0, pp_r, 32'd0};
    endcase
    case (sh_r)
      mvest_pkg::SH_0:  shv = acc_r;
      mvest_pkg::SH_8:  shv = acc_r >> 8;
      mvest_pkg::SH_16: shv = acc_r >> 16;
      default:          shv = acc_r >> 32;
    endcase
    case (lim_r)
      mvest_pkg::LS_WIDE:  limv = mvest_pkg::LIM_WIDE;
      mvest_pkg::LS_SIGMA: limv = mvest_pkg::LIM_SIGMA;
      mvest_pkg::LS_OUT:   limv = mvest_pkg::LIM_OUT;
      default:             limv = mvest_pkg::LIM_NONE;
    endcase
    magv = ((shv[127:64] != 64'd0) || (shv[63:0] > limv)) ? limv : shv[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        am_r   <= mvest_pkg::mag64(req.a);
        bm_r   <= mvest_pkg::mag64(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        sh_r   <= req.sh;
        lim_r  <= req.lim;
        acc_r  <= 128'd0;
        cnt_r  <= 3'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r < 3'd4) begin
          pp_r   <= a_part * b_part;
          pidx_r <= cnt_r[1:0];
        end
        if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
          acc_r <= acc_r + pp_sh;
        end
        if (cnt_r == 3'd5) begin
          res_r  <= neg_r ? $signed(64'd0 - magv) : $signed(magv);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

/* rtl/core/mvest_div.sv */
// ----------------------------------------------------------------------------
// mvest_div
// Shared signed 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvest_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mvest_pkg::div_req_t  req,
  output mvest_pkg::unit_rsp_t rsp
);

  logic [63:0]        num_r, den_r, rem_r;
  logic               neg_r, busy_r, done_r;
  logic [5:0]         cnt_r;
  logic signed [63:0] res_r;

  logic [64:0] tmp, diff;
  logic        ge;
  logic [63:0] q_new;

  assign tmp   = {rem_r, num_r[63]};
  assign diff  = tmp - {1'b0, den_r};
  assign ge    = tmp >= {1'b0, den_r};
  assign q_new = {num_r[62:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        num_r  <= mvest_pkg::mag64(req.num);
        den_r  <= mvest_pkg::mag64(req.den);
        neg_r  <= req.num[63] ^ req.den[63];
        rem_r  <= 64'd0;
        cnt_r  <= 6'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[63:0] : tmp[63:0];
        num_r <= q_new;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          res_r  <= neg_r ? $signed(64'd0 - q_new) : $signed(q_new);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

/* rtl/core/pixel_mean_variance_estimator_top.sv */
// ----------------------------------------------------------------------------
// pixel_mean_variance_estimator_top
// Per-pixel variance of the mean with a frame average, one item at a time.
// ----------------------------------------------------------------------------
// Sequence per pixel: a reciprocal of the weight, skipped at zero weight, and
//   a reciprocal of the weight less one, skipped at a weight of one, on the
//   shared divider; then 16 passes of the shared multiplier, and for a last
//   pixel the frame average on the divider. One pixel is in work at a time;
//   the next pixel is taken while a result waits.
// Reset: synchronous active low; clears the sequencer, running sum and count,
//   and loads the default luminance weights and clamp.
module pixel_mean_variance_estimator_top #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [23:0]        in_sample_weight,
  input  logic [39:0]        in_sum_red,
  input  logic [39:0]        in_sum_green,
  input  logic [39:0]        in_sum_blue,
  input  logic [47:0]        in_sumsq_red,
  input  logic [47:0]        in_sumsq_green,
  input  logic [47:0]        in_sumsq_blue,
  input  logic               in_last_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_pixel_variance,
  output logic signed [47:0] out_mean_variance,
  output logic               out_mean_valid
);

  localparam int PW = $clog2(MAX_PIXELS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RW   = 4'd1;
  localparam logic [3:0] ST_RWM1 = 4'd2;
  localparam logic [3:0] ST_CH   = 4'd3;
  localparam logic [3:0] ST_LUM  = 4'd4;
  localparam logic [3:0] ST_V    = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_AVG  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam logic [2:0] STEP_MEAN  = 3'd0;
  localparam logic [2:0] STEP_T     = 3'd1;
  localparam logic [2:0] STEP_WM2   = 3'd2;
  localparam logic [2:0] STEP_SIGMA = 3'd3;
  localparam logic [2:0] STEP_LUMA  = 3'd4;

  logic [3:0]  state_r, state_nxt;
  logic        issued_r;
  logic [2:0]  step_r;
  logic [1:0]  ch_r;
  logic [15:0] kr_r, kg_r, kb_r, clamp_r;

  logic [23:0] w_r;
  logic [39:0] s_r [3];
  logic [47:0] q_r [3];
  logic        last_r;

  logic signed [63:0] rw_r, rwm1_r, m_r, t_r, sig_r, lum_r, v_r, total_r, avg_r;
  logic [PW-1:0]      seen_r;

  logic               out_valid_r, out_mean_valid_r;
  logic signed [47:0] out_pv_r, out_mv_r;

  mvest_pkg::mul_req_t  mul_req;
  mvest_pkg::div_req_t  div_req;
  mvest_pkg::unit_rsp_t mul_rsp, div_rsp;

  logic signed [63:0] d_val, k_val, lum_q, cap, lum_cl, avg_cl;
  logic signed [64:0] sum65;
  logic signed [63:0] total_sat;

  mvest_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  mvest_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign d_val = $signed({40'd0, w_r}) - 64'sd256;

  always_comb begin
    case (ch_r)
      2'd0:    k_val = $signed({48'd0, kr_r});
      2'd1:    k_val = $signed({48'd0, kg_r});
      default: k_val = $signed({48'd0, kb_r});
    endcase
    lum_q = lum_r >>> 16;
    if (lum_r[63] && (lum_r[15:0] != 16'd0)) begin
      lum_q = lum_q + 64'sd1;
    end
    cap    = $signed({32'd0, clamp_r, 16'd0});
    lum_cl = (lum_q > cap) ? cap : lum_q;
    sum65  = {total_r[63], total_r} + {v_r[63], v_r};
    if (sum65[64] != sum65[63]) begin
      total_sat = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      total_sat = sum65[63:0];
    end
    if (div_rsp.res > $signed(mvest_pkg::LIM_OUT)) begin
      avg_cl = $signed(mvest_pkg::LIM_OUT);
    end else if (div_rsp.res < -$signed(mvest_pkg::LIM_OUT)) begin
      avg_cl = -$signed(mvest_pkg::LIM_OUT);
    end else begin
      avg_cl = div_rsp.res;
    end
  end

  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_r)
      ST_RW: begin
        div_req.num   = $signed(mvest_pkg::ONE_Q40);
        div_req.den   = $signed({40'd0, w_r});
        div_req.start = !issued_r && (w_r != 24'd0);
      end
      ST_RWM1: begin
        div_req.num   = $signed(mvest_pkg::ONE_Q40);
        div_req.den   = d_val;
        div_req.start = !issued_r && (d_val != 64'sd0);
      end
      ST_AVG: begin
        div_req.num   = total_r;
        div_req.den   = $signed({{(64-PW){1'b0}}, seen_r});
        div_req.start = !issued_r && last_r;
      end
      ST_CH: begin
        mul_req.start = !issued_r;
        case (step_r)
          STEP_MEAN: begin
            mul_req.a   = $signed({24'd0, s_r[ch_r]});
            mul_req.b   = rw_r;
            mul_req.sh  = mvest_pkg::SH_32;
            mul_req.lim = mvest_pkg::LS_WIDE;
          end
          STEP_T: begin
            mul_req.a   = $signed({40'd0, w_r});
            mul_req.b   = m_r;
            mul_req.sh  = mvest_pkg::SH_8;
            mul_req.lim = mvest_pkg::LS_WIDE;
          end
          STEP_WM2: begin
            mul_req.a   = t_r;
            mul_req.b   = m_r;
            mul_req.sh  = mvest_pkg::SH_16;
            mul_req.lim = mvest_pkg::LS_WIDE;
          end
          STEP_SIGMA: begin
            mul_req.a   = $signed({16'd0, q_r[ch_r]}) - t_r;
            mul_req.b   = rwm1_r;
            mul_req.sh  = mvest_pkg::SH_32;
            mul_req.lim = mvest_pkg::LS_SIGMA;
          end
          default: begin
            mul_req.a   = k_val;
            mul_req.b   = sig_r;
            mul_req.sh  = mvest_pkg::SH_0;
            mul_req.lim = mvest_pkg::LS_NONE;
          end
        endcase
      end
      ST_V: begin
        mul_req.start = !issued_r;
        mul_req.a     = lum_r;
        mul_req.b     = rw_r;
        mul_req.sh    = mvest_pkg::SH_32;
        mul_req.lim   = mvest_pkg::LS_OUT;
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RW;
      ST_RW:   if (w_r == 24'd0 || (issued_r && div_rsp.done)) state_nxt = ST_RWM1;
      ST_RWM1: if (d_val == 64'sd0 || (issued_r && div_rsp.done)) state_nxt = ST_CH;
      ST_CH: begin
        if (issued_r && mul_rsp.done && step_r == STEP_LUMA && ch_r == 2'd2) begin
          state_nxt = ST_LUM;
        end
      end
      ST_LUM:  state_nxt = ST_V;
      ST_V:    if (issued_r && mul_rsp.done) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_AVG;
      ST_AVG:  if (!last_r || (issued_r && div_rsp.done)) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      step_r      <= STEP_MEAN;
      ch_r        <= 2'd0;
      total_r     <= 64'sd0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      kr_r        <= mvest_pkg::RST_LUMA_RED;
      kg_r        <= mvest_pkg::RST_LUMA_GREEN;
      kb_r        <= mvest_pkg::RST_LUMA_BLUE;
      clamp_r     <= mvest_pkg::RST_CLAMP;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mvest_pkg::CFG_LUMA_RED:   kr_r    <= cfg_wdata;
          mvest_pkg::CFG_LUMA_GREEN: kg_r    <= cfg_wdata;
          mvest_pkg::CFG_LUMA_BLUE:  kb_r    <= cfg_wdata;
          default:                   clamp_r <= cfg_wdata;
        endcase
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            w_r      <= in_sample_weight;
            s_r[0]   <= in_sum_red;
            s_r[1]   <= in_sum_green;
            s_r[2]   <= in_sum_blue;
            q_r[0]   <= in_sumsq_red;
            q_r[1]   <= in_sumsq_green;
            q_r[2]   <= in_sumsq_blue;
            last_r   <= in_last_pixel;
            issued_r <= 1'b0;
          end
        end
        ST_RW: begin
          if (w_r == 24'd0) begin
            rw_r <= 64'sd0;
          end else if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (div_rsp.done) begin
            rw_r     <= div_rsp.res;
            issued_r <= 1'b0;
          end
        end
        ST_RWM1: begin
          ch_r   <= 2'd0;
          step_r <= STEP_MEAN;
          lum_r  <= 64'sd0;
          if (d_val == 64'sd0) begin
            rwm1_r <= 64'sd0;
          end else if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (div_rsp.done) begin
            rwm1_r   <= div_rsp.res;
            issued_r <= 1'b0;
          end
        end
        ST_CH: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (mul_rsp.done) begin
            issued_r <= 1'b0;
            case (step_r)
              STEP_MEAN: begin
                m_r    <= mul_rsp.res;
                step_r <= step_r + 3'd1;
              end
              STEP_T: begin
                t_r    <= mul_rsp.res;
                step_r <= step_r + 3'd1;
              end
              STEP_WM2: begin
                t_r    <= mul_rsp.res;
                step_r <= step_r + 3'd1;
              end
              STEP_SIGMA: begin
                sig_r  <= mul_rsp.res;
                step_r <= step_r + 3'd1;
              end
              default: begin
                lum_r  <= lum_r + mul_rsp.res;
                step_r <= STEP_MEAN;
                ch_r   <= ch_r + 2'd1;
              end
            endcase
          end
        end
        ST_LUM: begin
          lum_r <= lum_cl;
        end
        ST_V: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (mul_rsp.done) begin
            v_r      <= mul_rsp.res;
            issued_r <= 1'b0;
          end
        end
        ST_ACC: begin
          total_r <= total_sat;
          if (seen_r < PW'(MAX_PIXELS)) begin
            seen_r <= seen_r + PW'(1);
          end
          avg_r <= 64'sd0;
        end
        ST_AVG: begin
          if (last_r) begin
            if (!issued_r) begin
              issued_r <= 1'b1;
            end else if (div_rsp.done) begin
              avg_r    <= avg_cl;
              total_r  <= 64'sd0;
              seen_r   <= '0;
              issued_r <= 1'b0;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_pv_r         <= v_r[47:0];
            out_mv_r         <= avg_r[47:0];
            out_mean_valid_r <= last_r;
          end
        end
        default: begin
          issued_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_pixel_variance = out_pv_r;
  assign out_mean_variance  = out_mv_r;
  assign out_mean_valid     = out_mean_valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted transaction did not hold off the input");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_rsp.busy && div_rsp.busy))
    else $error("multiplier and divider busy together");

  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!mul_rsp.busy && !div_rsp.busy))
    else $error("shared unit busy while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= PW'(MAX_PIXELS))
    else $error("pixel count beyond limit");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pixel_mean_variance_estimator_top. A directed table
// covers zero weight, unit weight, weight below one, inconsistent sums, field
// extremes and frame ends. Random frames follow: mostly consistent pixel sums
// with a share of raw noise. Typed rows are checked field by field with the
// table, all others with a built-in fixed-point model of the variance, clamp
// and frame average, over several register settings and in/out idling mixes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  PIXEL_CAP   = 1048576;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam longint I64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN  = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

  typedef struct {
    logic [23:0] weight;
    logic [39:0] sum [3];
    logic [47:0] sumsq [3];
    logic        last;
  } pixel_t;

  typedef struct {
    logic [47:0] pix_var;
    logic [47:0] avg_var;
    logic        avg_valid;
  } variance_t;

  typedef struct {
    pixel_t    px;
    bit        typed;
    variance_t res;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [23:0]        in_sample_weight = '0;
  logic [39:0]        in_sum_red = '0, in_sum_green = '0, in_sum_blue = '0;
  logic [47:0]        in_sumsq_red = '0, in_sumsq_green = '0, in_sumsq_blue = '0;
  logic               in_last_pixel = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [47:0] out_pixel_variance;
  logic signed [47:0] out_mean_variance;
  logic               out_mean_valid;

  pixel_mean_variance_estimator_top u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [15:0] luma_r, luma_g, luma_b, clamp_int;
  longint      frame_total;
  int unsigned frame_count;
  variance_t   pending_q[$];
  int          tx_idle_pct, rx_idle_pct;
  bit          failed;
  int          cycles;

  function automatic longint scaled_product(longint a, longint b, int sh,
                                            logic [63:0] lim);
    logic [63:0]  ma, mb, v;
    logic [127:0] p;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    p   = ({64'd0, ma} * {64'd0, mb}) >> sh;
    v   = (p > {64'd0, lim}) ? lim : p[63:0];
    return neg ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint channel_var(longint s, longint q, longint w,
                                         longint rw, longint rwm1);
    longint m, t, wm2;
    m   = scaled_product(s, rw, 32, mvest_pkg::LIM_WIDE);
    t   = scaled_product(w, m, 8, mvest_pkg::LIM_WIDE);
    wm2 = scaled_product(t, m, 16, mvest_pkg::LIM_WIDE);
    return scaled_product(q - wm2, rwm1, 32, mvest_pkg::LIM_SIGMA);
  endfunction

  function automatic variance_t estimate_variance(pixel_t px);
    variance_t r;
    longint    w, rw, d, rwm1, lum, cap, v, avg;
    longint    sig [3];
    w    = longint'(px.weight);
    rw   = (w == 0) ? 0 : longint'((64'd1 << 40) / px.weight);
    d    = w - 256;
    rwm1 = (d == 0) ? 0 : (longint'(1) <<< 40) / d;
    for (int c = 0; c < 3; c++)
      sig[c] = channel_var(longint'(px.sum[c]), longint'(px.sumsq[c]), w, rw, rwm1);
    lum = (longint'(luma_r) * sig[0] + longint'(luma_g) * sig[1]
           + longint'(luma_b) * sig[2]) / 65536;
    cap = longint'(clamp_int) * 65536;
    if (lum > cap) lum = cap;
    v = scaled_product(lum, rw, 32, mvest_pkg::LIM_OUT);
    if (v > 0 && frame_total > I64_MAX - v) frame_total = I64_MAX;
    else if (v < 0 && frame_total < I64_MIN - v) frame_total = I64_MIN;
    else frame_total += v;
    if (frame_count < PIXEL_CAP) frame_count++;
    r.pix_var   = v[47:0];
    r.avg_var   = '0;
    r.avg_valid = 1'b0;
    if (px.last) begin
      avg = frame_total / longint'(frame_count);
      if (avg > longint'(mvest_pkg::LIM_OUT)) avg = longint'(mvest_pkg::LIM_OUT);
      else if (avg < -longint'(mvest_pkg::LIM_OUT)) avg = -longint'(mvest_pkg::LIM_OUT);
      r.avg_var   = avg[47:0];
      r.avg_valid = 1'b1;
      frame_total = 0;
      frame_count = 0;
    end
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      mvest_pkg::CFG_LUMA_RED:   luma_r = val;
      mvest_pkg::CFG_LUMA_GREEN: luma_g = val;
      mvest_pkg::CFG_LUMA_BLUE:  luma_b = val;
      default:                   clamp_int = val;
    endcase
  endtask

  task automatic load_regs(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [15:0] c);
    write_reg(mvest_pkg::CFG_LUMA_RED, r);
    write_reg(mvest_pkg::CFG_LUMA_GREEN, g);
    write_reg(mvest_pkg::CFG_LUMA_BLUE, b);
    write_reg(mvest_pkg::CFG_CLAMP, c);
  endtask

  task automatic send_pixel(pixel_t px, bit typed, variance_t typed_res);
    variance_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_sample_weight <= px.weight;
    in_sum_red       <= px.sum[0];
    in_sum_green     <= px.sum[1];
    in_sum_blue      <= px.sum[2];
    in_sumsq_red     <= px.sumsq[0];
    in_sumsq_green   <= px.sumsq[1];
    in_sumsq_blue    <= px.sumsq[2];
    in_last_pixel    <= px.last;
    do @(posedge clk); while (in_stall);
    r = estimate_variance(px);
    pending_q.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [31:0] mu;
    px.last = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0:       px.weight = 24'($urandom_range(0, 512));
        1:       px.weight = 24'($urandom_range(257, 4096));
        2:       px.weight = 24'($urandom_range(257, 65535));
        default: px.weight = 24'($urandom_range(257, 24'hFFFFFF));
      endcase
      for (int c = 0; c < 3; c++) begin
        mu          = $urandom_range(0, 32'h4_0000);
        px.sum[c]   = 40'((64'(px.weight) * mu) >> 8);
        px.sumsq[c] = 48'(((64'(px.sum[c]) * mu) >> 16)
                      + ((64'(px.weight) * $urandom_range(0, 32'h1_0000)) >> 8));
      end
    end else begin
      px.weight = 24'($urandom);
      for (int c = 0; c < 3; c++) begin
        px.sum[c]   = 40'({$urandom, $urandom});
        px.sumsq[c] = 48'({$urandom, $urandom});
      end
    end
    return px;
  endfunction

  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction");
        failed = 1'b1;
      end else begin
        variance_t e;
        e = pending_q.pop_front();
        if (out_pixel_variance !== e.pix_var) begin
          $error("pixel_variance expected %h actual %h", e.pix_var, out_pixel_variance);
          failed = 1'b1;
        end
        if (out_mean_variance !== e.avg_var) begin
          $error("mean_variance expected %h actual %h", e.avg_var, out_mean_variance);
          failed = 1'b1;
        end
        if (out_mean_valid !== e.avg_valid) begin
          $error("mean_valid expected %b actual %b", e.avg_valid, out_mean_valid);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic row_t make_row(logic [23:0] w, logic [39:0] s, logic [47:0] q,
                                    logic last, bit typed, logic [47:0] avg);
    row_t rw;
    rw.px.weight = w;
    for (int c = 0; c < 3; c++) begin
      rw.px.sum[c]   = s;
      rw.px.sumsq[c] = q;
    end
    rw.px.last        = last;
    rw.typed          = typed;
    rw.res.pix_var    = '0;
    rw.res.avg_var    = avg;
    rw.res.avg_valid  = last;
    return rw;
  endfunction

  row_t      rows[$];
  variance_t none;
  logic [15:0] cfg_set [6][4];

  initial begin
    failed = 1'b0;
    cycles = 0;
    luma_r = mvest_pkg::RST_LUMA_RED; luma_g = mvest_pkg::RST_LUMA_GREEN;
    luma_b = mvest_pkg::RST_LUMA_BLUE; clamp_int = mvest_pkg::RST_CLAMP;
    frame_total = 0;
    frame_count = 0;
    tx_idle_pct = 25;
    rx_idle_pct = 82;
    none = '{default: '0};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows.push_back(make_row(24'd0, 40'd0, 48'd0, 1'b0, 1, 48'd0));
    rows.push_back(make_row(24'd0, '1, '1, 1'b0, 1, 48'd0));
    rows.push_back(make_row(24'd256, 40'h12_3456_789A, 48'h1234_5678_9ABC, 1'b0, 1, 48'd0));
    rows.push_back(make_row(24'd256, '1, '1, 1'b1, 1, 48'd0));
    rows.push_back(make_row(24'd1, 40'h1_0000, 48'h1_0000, 1'b0, 0, 48'd0));
    rows.push_back(make_row(24'd128, 40'h8000, 48'h1_0000, 1'b0, 0, 48'd0));
    rows.push_back(make_row(24'd255, 40'hFF_0000, 48'd0, 1'b0, 0, 48'd0));
    rows.push_back(make_row(24'd1024, 40'h400_0000, 48'd0, 1'b0, 0, 48'd0));
    rows.push_back(make_row(24'd1024, 40'h400_0000, 48'h1000_0000, 1'b0, 0, 48'd0));
    rows.push_back(make_row(24'd1024, 40'h200_0000, 48'h100_0000, 1'b1, 0, 48'd0));
    rows.push_back(make_row(24'd1, '1, '1, 1'b0, 0, 48'd0));
    rows.push_back(make_row(24'd1, '1, 48'd0, 1'b0, 0, 48'd0));
    rows.push_back(make_row('1, '1, '1, 1'b0, 0, 48'd0));
    rows.push_back(make_row('1, 40'd0, '1, 1'b0, 0, 48'd0));
    rows.push_back(make_row(24'd257, 40'd0, '1, 1'b0, 0, 48'd0));
    rows.push_back(make_row(24'd512, 40'h2_0000, 48'h3_0000, 1'b1, 0, 48'd0));
    rows.push_back(make_row(24'h80_0000, 40'h80_0000_0000, 48'h8000_0000_0000,
                            1'b1, 0, 48'd0));
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].typed, rows[i].res);
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);

    cfg_set[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    cfg_set[1] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    cfg_set[2] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    cfg_set[3] = '{mvest_pkg::RST_LUMA_RED, mvest_pkg::RST_LUMA_GREEN,
                   mvest_pkg::RST_LUMA_BLUE, mvest_pkg::RST_CLAMP};
    cfg_set[4] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 8))};
    cfg_set[5] = '{16'h0000, 16'hFFFF, 16'h0001, 16'($urandom)};
    for (int ph = 0; ph < 6; ph++) begin
      repeat (20) @(negedge clk);
      load_regs(cfg_set[ph][0], cfg_set[ph][1], cfg_set[ph][2], cfg_set[ph][3]);
      tx_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 82 : 0;
      rx_idle_pct = (ph < 2) ? 82 : (ph < 4) ? 25 : 0;
      for (int n = 0; n < 305; n++) send_pixel(random_pixel(), 0, none);
      in_valid <= 1'b0;
      wait (pending_q.size() == 0);
    end

    repeat (400) @(posedge clk);
    if (!failed && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/mvest_pkg.sv
rtl/core/mvest_mul.sv
rtl/core/mvest_div.sv
rtl/core/pixel_mean_variance_estimator_top.sv
tb/testbench.sv
